/* design/lse_pkg.sv */
// Shared constants, codes and types for the LIFO stack engine.
package lse_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int STAT_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_DUMP = 3'd1,
    OP_PEEK = 3'd2,
    OP_POP  = 3'd3,
    OP_SWAP = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_SHORT = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEEK,
    ST_SWAP_RD,
    ST_SWAP_WR1,
    ST_SWAP_WR2,
    ST_DUMP
  } state_t;

endpackage

/* design/lse_if.sv */
// Valid/ready channel interfaces for instructions and results.
interface lse_in_if
  import lse_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface lse_out_if
  import lse_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] item_value;
  logic                     has_value;
  logic [STAT_W-1:0]        status;
  logic                     last;

  modport source (output valid, output item_value, output has_value, output status,
                  output last, input ready);
  modport sink   (input valid, input item_value, input has_value, input status,
                  input last, output ready);
endinterface

/* design/lse_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/lse_ctrl.sv */
// Instruction sequencer: entry count, RAM read-modify-write and result register.
module lse_ctrl
  import lse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  lse_in_if.sink            in_ch,
  lse_out_if.source         out_ch,
  output logic              ram_wr_en,
  output logic [ADDR_W-1:0] ram_wr_addr,
  output logic [DATA_W-1:0] ram_wr_data,
  output logic              ram_rd_en,
  output logic [ADDR_W-1:0] ram_rd_addr,
  input  logic [DATA_W-1:0] ram_rd_data
);

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [ADDR_W-1:0]        ptr_r, ptr_nxt;
  logic [DATA_W-1:0]        tmp_r, tmp_nxt;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_has_r;
  status_t                  out_status_r;
  logic                     out_last_r;

  logic                     emit;
  logic [DATA_W-1:0]        e_value;
  logic                     e_has;
  status_t                  e_status;
  logic                     e_last;

  logic                     out_free;
  logic                     acc;
  logic                     empty, full, short;
  logic [CNT_W-1:0]         cnt_m1, cnt_m2;
  logic [ADDR_W-1:0]        top_addr, below_addr, ptr_m1;
  op_t                      op;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign acc        = in_ch.valid && in_ch.ready;
  assign op         = op_t'(in_ch.op);

  assign empty      = (count_r == '0);
  assign full       = (count_r == CNT_W'(STACK_DEPTH));
  assign short      = (count_r < CNT_W'(2));
  assign cnt_m1     = count_r - CNT_W'(1);
  assign cnt_m2     = count_r - CNT_W'(2);
  assign top_addr   = cnt_m1[ADDR_W-1:0];
  assign below_addr = cnt_m2[ADDR_W-1:0];
  assign ptr_m1     = ptr_r - ADDR_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (op)
            OP_DUMP: if (!empty) state_nxt = ST_DUMP;
            OP_PEEK: if (!empty) state_nxt = ST_PEEK;
            OP_SWAP: if (!short) state_nxt = ST_SWAP_RD;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PEEK:     if (out_free) state_nxt = ST_IDLE;
      ST_SWAP_RD:  state_nxt = ST_SWAP_WR1;
      ST_SWAP_WR1: state_nxt = ST_SWAP_WR2;
      ST_SWAP_WR2: if (out_free) state_nxt = ST_IDLE;
      ST_DUMP:     if (out_free && ptr_r == '0) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = count_r[ADDR_W-1:0];
    ram_wr_data = in_ch.push_value;
    ram_rd_en   = 1'b0;
    ram_rd_addr = top_addr;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    tmp_nxt     = tmp_r;
    emit        = 1'b0;
    e_value     = '0;
    e_has       = 1'b0;
    e_status    = STAT_OK;
    e_last      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (op)
            OP_PUSH: begin
              emit = 1'b1;
              if (full) begin
                e_status = STAT_FULL;
              end else begin
                ram_wr_en = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_DUMP: begin
              if (empty) begin
                emit = 1'b1;
              end else begin
                ram_rd_en = 1'b1;
                ptr_nxt   = top_addr;
              end
            end
            OP_PEEK: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = STAT_EMPTY;
              end else begin
                ram_rd_en = 1'b1;
              end
            end
            OP_POP: begin
              emit = 1'b1;
              if (empty) begin
                e_status = STAT_EMPTY;
              end else begin
                count_nxt = cnt_m1;
              end
            end
            OP_SWAP: begin
              if (short) begin
                emit     = 1'b1;
                e_status = STAT_SHORT;
              end else begin
                ram_rd_en = 1'b1;
              end
            end
            default: emit = 1'b0;
          endcase
        end
      end
      ST_PEEK: begin
        if (out_free) begin
          emit    = 1'b1;
          e_value = ram_rd_data;
          e_has   = 1'b1;
        end
      end
      ST_SWAP_RD: begin
        // hold top word, fetch the one below
        tmp_nxt     = ram_rd_data;
        ram_rd_en   = 1'b1;
        ram_rd_addr = below_addr;
      end
      ST_SWAP_WR1: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = top_addr;
        ram_wr_data = ram_rd_data;
      end
      ST_SWAP_WR2: begin
        if (out_free) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = below_addr;
          ram_wr_data = tmp_r;
          emit        = 1'b1;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          emit    = 1'b1;
          e_value = ram_rd_data;
          e_has   = 1'b1;
          e_last  = (ptr_r == '0);
          if (ptr_r != '0) begin
            // advance to the next word down
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_m1;
            ptr_nxt     = ptr_m1;
          end
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    tmp_r <= tmp_nxt;
    if (emit) begin
      out_value_r  <= e_value;
      out_has_r    <= e_has;
      out_status_r <= e_status;
      out_last_r   <= e_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.item_value = out_value_r;
  assign out_ch.has_value  = out_has_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.last       = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("entry count above stack depth");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == ST_IDLE)
    else $error("instruction taken while sequencer busy");

  a_dump_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DUMP |-> {1'b0, ptr_r} < count_r)
    else $error("dump pointer outside the stack");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PEEK || state_r == ST_DUMP) |-> !ram_wr_en)
    else $error("store written during peek or dump");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op == OP_POP && !empty) |=> count_r == $past(cnt_m1))
    else $error("pop did not drop the entry count");

endmodule

/* design/lse_stack_engine_top.sv */
// Top level of the LIFO stack engine: sequencer plus entry RAM.
//
//  channel   dir  handshake          word
//  in_ch     in   valid/ready        op, push_value
//  out_ch    out  valid/ready        item_value, has_value, status, last
//
// Push, pop and every error result are emitted directly from idle; peek reads the RAM first.
// Swap makes two reads and two writes through the single RAM port pair.
// Dump makes one RAM read per word delivered.
// Reset clears the entry count and the result valid flag; the RAM is not cleared.
// A stalled out_ch holds the sequencer; a waiting result holds off the next instruction
// until out_ch takes it.
module lifo_stack_engine
  import lse_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  lse_in_if.sink    in_ch,
  lse_out_if.source out_ch
);

  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [DATA_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [DATA_W-1:0] ram_rd_data;

  lse_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  lse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
